@@ rtl/zb32_pkg.sv @@
// ----------------------------------------------------------------------------
// zb32_pkg
// Shared types, constants and the character table for the z-base-32 encoder.
// ----------------------------------------------------------------------------
package zb32_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned GroupW = 5;
  localparam int unsigned CntW   = 3;
  localparam int unsigned PendW  = 4;
  localparam int unsigned AccW   = PendW + ByteW;
  localparam int unsigned NumW   = 2;

  typedef struct packed {
    logic              vld;
    logic [AccW-1:0]   acc;
    logic [NumW-1:0]   nchar;
    logic              last;
  } work_t;

  function automatic logic [ByteW-1:0] zb32_char(input logic [GroupW-1:0] idx);
    logic [ByteW-1:0] c;
    case (idx)
      5'd0:    c = "y";
      5'd1:    c = "b";
      5'd2:    c = "n";
      5'd3:    c = "d";
      5'd4:    c = "r";
      5'd5:    c = "f";
      5'd6:    c = "g";
      5'd7:    c = "8";
      5'd8:    c = "e";
      5'd9:    c = "j";
      5'd10:   c = "k";
      5'd11:   c = "m";
      5'd12:   c = "c";
      5'd13:   c = "p";
      5'd14:   c = "q";
      5'd15:   c = "x";
      5'd16:   c = "o";
      5'd17:   c = "t";
      5'd18:   c = "1";
      5'd19:   c = "u";
      5'd20:   c = "w";
      5'd21:   c = "i";
      5'd22:   c = "s";
      5'd23:   c = "z";
      5'd24:   c = "a";
      5'd25:   c = "3";
      5'd26:   c = "4";
      5'd27:   c = "5";
      5'd28:   c = "h";
      5'd29:   c = "7";
      5'd30:   c = "6";
      5'd31:   c = "9";
      default: c = "y";
    endcase
    return c;
  endfunction

endpackage

@@ rtl/zb32_if.sv @@
// ----------------------------------------------------------------------------
// zb32_if
// Valid/ready channels for raw bytes in and encoded characters out.
// ----------------------------------------------------------------------------
interface zb32_byte_if;
  import zb32_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             end_of_string;

  modport source(output valid, output data_byte, output end_of_string, input ready);
  modport sink(input valid, input data_byte, input end_of_string, output ready);
endinterface

interface zb32_char_if;
  import zb32_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] code_char;
  logic             final_char;
  logic             string_done;

  modport source(output valid, output code_char, output final_char, output string_done,
                 input ready);
  modport sink(input valid, input code_char, input final_char, input string_done,
               output ready);
endinterface

@@ rtl/zb32_pack.sv @@
// ----------------------------------------------------------------------------
// zb32_pack
// Merges each byte with the pending bits, updates the pending state and
// holds the merged word for the character stage.
// ----------------------------------------------------------------------------
module zb32_pack (
  input  logic             clk_i,
  input  logic             rst_ni,
  zb32_byte_if.sink        byte_i,
  input  logic             take_i,
  output zb32_pkg::work_t  work_o
);
  import zb32_pkg::*;

  logic [PendW-1:0] pend_bits_q, pend_bits_d;
  logic [CntW-1:0]  pend_cnt_q, pend_cnt_d;
  work_t            work_q, work_d;
  logic             accept;
  logic [AccW-1:0]  acc;
  logic [PendW-1:0] total;
  logic             two_grp;
  logic [PendW-1:0] left;

  assign byte_i.ready = !work_q.vld || take_i;
  assign accept       = byte_i.valid && byte_i.ready;

  always_comb begin
    acc     = {{ByteW{1'b0}}, pend_bits_q} |
              ({{PendW{1'b0}}, byte_i.data_byte} << pend_cnt_q);
    total   = {1'b0, pend_cnt_q} + PendW'(ByteW);
    two_grp = total >= PendW'(2 * GroupW);
    left    = two_grp ? total - PendW'(2 * GroupW) : total - PendW'(GroupW);

    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    work_d      = work_q;
    if (take_i) begin
      work_d.vld = 1'b0;
    end
    if (accept) begin
      work_d.vld   = 1'b1;
      work_d.acc   = acc;
      work_d.last  = byte_i.end_of_string;
      work_d.nchar = two_grp ? NumW'(2) : NumW'(1);
      if (byte_i.end_of_string) begin
        if (left != '0) begin
          work_d.nchar = work_d.nchar + NumW'(1);
        end
        pend_bits_d = '0;
        pend_cnt_d  = '0;
      end else begin
        pend_bits_d = two_grp ? {2'b00, acc[AccW-1:2*GroupW]}
                              : acc[GroupW+PendW-1:GroupW];
        pend_cnt_d  = left[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      work_q      <= '0;
    end else begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      work_q      <= work_d;
    end
  end

  assign work_o = work_q;

endmodule

@@ rtl/zb32_emit.sv @@
// ----------------------------------------------------------------------------
// zb32_emit
// Steps through the groups of the held word, one character per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module zb32_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  zb32_pkg::work_t  work_i,
  output logic             take_o,
  zb32_char_if.source      char_o
);
  import zb32_pkg::*;

  logic [NumW-1:0]   idx_q, idx_d;
  logic              out_vld_q, out_vld_d;
  logic [ByteW-1:0]  char_q;
  logic              fin_q, done_q;
  logic              move;
  logic              is_final;
  logic [GroupW-1:0] grp;

  assign move     = work_i.vld && (!out_vld_q || char_o.ready);
  assign is_final = idx_q == work_i.nchar - NumW'(1);
  assign take_o   = move && is_final;

  always_comb begin
    case (idx_q)
      2'd0:    grp = work_i.acc[GroupW-1:0];
      2'd1:    grp = work_i.acc[2*GroupW-1:GroupW];
      default: grp = {3'b000, work_i.acc[AccW-1:2*GroupW]};
    endcase

    idx_d     = idx_q;
    out_vld_d = out_vld_q && !char_o.ready;
    if (move) begin
      out_vld_d = 1'b1;
      idx_d     = is_final ? '0 : idx_q + NumW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      char_q <= zb32_char(grp);
      fin_q  <= is_final;
      done_q <= is_final && work_i.last;
    end
  end

  assign char_o.valid       = out_vld_q;
  assign char_o.code_char   = char_q;
  assign char_o.final_char  = fin_q;
  assign char_o.string_done = done_q;

endmodule

@@ rtl/zbase32_byte_encoder_top.sv @@
// ----------------------------------------------------------------------------
// zbase32_byte_encoder_top
// Encodes a byte stream into z-base-32 characters, least significant bit first.
// ----------------------------------------------------------------------------
// Each accepted byte goes to the held-word register, then to the output register.
// Throughput: one character per cycle from the character stage while the output
// is not stalled; an item makes one to three characters, 1.6 on average.
// Reset clears the pending bits and the valid flags of both stages.
module zbase32_byte_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  zb32_byte_if.sink   byte_i,
  zb32_char_if.source char_o
);
  import zb32_pkg::*;

  work_t work;
  logic  take;

  zb32_pack u_pack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .take_i (take),
    .work_o (work)
  );

  zb32_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .work_i (work),
    .take_o (take),
    .char_o (char_o)
  );

`ifndef SYNTHESIS
  a_take_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> work.vld) else $error("held word released while empty");

  a_nchar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work.vld |-> (work.nchar != '0)) else $error("held word has no characters");

  a_done_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_o.valid && char_o.string_done) |-> char_o.final_char)
    else $error("end of string on a character that is not final");

  a_accept_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_i.valid && work.vld && !take) |-> !byte_i.ready)
    else $error("byte accepted over a held word");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the z-base-32 byte encoder. A driver feeds strings
// of raw bytes in random bursts, an encoder model predicts every character,
// and a monitor with its own stall pattern checks each character in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import zb32_pkg::*;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             eos;
    logic             hold;
  } byte_item_t;

  typedef struct {
    logic [ByteW-1:0] code;
    logic             fin;
    logic             done;
  } char_item_t;

  localparam logic [8*32-1:0] ZB_ALPHABET = "ybndrfg8ejkmcpqxot1uwisza345h769";

  localparam int unsigned RdyAlways   = 0;
  localparam int unsigned RdyRandom   = 1;
  localparam int unsigned RdyPeriodic = 2;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             src_valid = 1'b0;
  logic [ByteW-1:0] src_data = '0;
  logic             src_eos = 1'b0;
  logic             snk_ready = 1'b0;

  zb32_byte_if byte_if ();
  zb32_char_if char_if ();

  assign byte_if.valid         = src_valid;
  assign byte_if.data_byte     = src_data;
  assign byte_if.end_of_string = src_eos;
  assign char_if.ready         = snk_ready;

  zbase32_byte_encoder_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if.sink),
    .char_o (char_if.source)
  );

  byte_item_t stim_q[$];
  char_item_t char_q[$];
  int unsigned errors = 0;

  logic [PendW-1:0] model_bits = '0;
  logic [CntW-1:0]  model_cnt = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ByteW-1:0] zb_char(input logic [GroupW-1:0] idx);
    return ZB_ALPHABET[8*(31-idx) +: 8];
  endfunction

  task automatic encode_byte(input logic [ByteW-1:0] data, input logic eos);
    logic [AccW-1:0] acc;
    int unsigned     cnt;
    char_item_t      c;
    acc = {{PendW{1'b0}}, data};
    acc = (acc << model_cnt) | {{ByteW{1'b0}}, model_bits};
    cnt = model_cnt + ByteW;
    while (cnt >= GroupW) begin
      c.code = zb_char(acc[GroupW-1:0]);
      c.fin  = 1'b0;
      c.done = 1'b0;
      char_q.push_back(c);
      acc = acc >> GroupW;
      cnt = cnt - GroupW;
    end
    if (eos) begin
      if (cnt != 0) begin
        c.code = zb_char(acc[GroupW-1:0]);
        c.fin  = 1'b0;
        c.done = 1'b0;
        char_q.push_back(c);
      end
      char_q[char_q.size()-1].done = 1'b1;
      acc = '0;
      cnt = 0;
    end
    char_q[char_q.size()-1].fin = 1'b1;
    model_bits = acc[PendW-1:0];
    model_cnt  = cnt[CntW-1:0];
  endtask

  task automatic add_string(input int unsigned len, input int unsigned style,
                            input logic hold);
    byte_item_t it;
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        0: it.data = 8'h00;
        1: it.data = 8'hFF;
        2: it.data = (i % 2 == 0) ? 8'hA5 : 8'h5A;
        3: it.data = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
        default: it.data = 8'($urandom_range(0, 255));
      endcase
      it.eos  = (i == len - 1);
      it.hold = hold && (i == 0);
      stim_q.push_back(it);
    end
  endtask

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && byte_if.ready) begin
        encode_byte(src_data, src_eos);
      end
      if (!src_valid || byte_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          src_valid <= 1'b0;
        end else if (stim_q.size() == 0) begin
          src_valid <= 1'b0;
        end else if (stim_q[0].hold && char_q.size() != 0) begin
          src_valid <= 1'b0;
        end else begin
          src_valid <= 1'b1;
          src_data  <= stim_q[0].data;
          src_eos   <= stim_q[0].eos;
          void'(stim_q.pop_front());
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  int unsigned rdy_mode = RdyAlways;
  int unsigned rdy_left = 0;
  int unsigned rdy_tick = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snk_ready <= 1'b0;
    end else begin
      if (char_if.valid && snk_ready) begin
        if (char_q.size() == 0) begin
          $error("unexpected character: code_char %h", char_if.code_char);
          errors++;
        end else begin
          if (char_if.code_char !== char_q[0].code) begin
            $error("code_char: expected %h, actual %h", char_q[0].code, char_if.code_char);
            errors++;
          end
          if (char_if.final_char !== char_q[0].fin) begin
            $error("final_char: expected %b, actual %b", char_q[0].fin, char_if.final_char);
            errors++;
          end
          if (char_if.string_done !== char_q[0].done) begin
            $error("string_done: expected %b, actual %b", char_q[0].done,
                   char_if.string_done);
            errors++;
          end
          void'(char_q.pop_front());
        end
      end
      if (rdy_left == 0) begin
        rdy_mode = $urandom_range(RdyAlways, RdyPeriodic);
        rdy_left = $urandom_range(20, 80);
      end else begin
        rdy_left--;
      end
      rdy_tick++;
      case (rdy_mode)
        RdyAlways: begin
          snk_ready <= 1'b1;
        end
        RdyRandom: begin
          snk_ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          snk_ready <= (rdy_tick % 4 == 0);
        end
      endcase
    end
  end

  initial begin
    int unsigned queued;
    add_string(1, 0, 1'b0);
    add_string(1, 1, 1'b0);
    add_string(2, 1, 1'b0);
    add_string(3, 2, 1'b0);
    add_string(4, 0, 1'b0);
    add_string(5, 1, 1'b1);
    add_string(5, 0, 1'b0);
    queued = stim_q.size();
    while (queued < 420) begin
      int unsigned len;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : $urandom_range(1, 16);
      add_string(len, ($urandom_range(0, 5) == 0) ? 3 : 4,
                 (queued == 21) || ($urandom_range(0, 9) == 0));
      queued += len;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || src_valid) @(posedge clk_i);
    while (char_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (errors == 0 && char_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
